[hw/rtl/peds_pkg.sv]
// Package for the periodic earliest-due scheduler.
// Command and status codes, sequencer states. No dependencies.
`timescale 1ns / 1ps
package peds_pkg;
	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_SERVE = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_OVF   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_TOP_RD,
		S_TOP_CHK,
		S_DN_RDL,
		S_DN_RDR,
		S_DN_CMPL,
		S_DN_CMPR,
		S_DN_WR,
		S_DONE
	} state_t;

	localparam int CMD_W    = 2;
	localparam int PERIOD_W = 16;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 11;
	localparam int SEND_W   = 48;
endpackage

[hw/rtl/peds_if.sv]
// Valid/ready channel interfaces for the scheduler.
// Depends on peds_pkg.
`timescale 1ns / 1ps
interface peds_req_if;
	logic                          valid;
	logic                          ready;
	logic [peds_pkg::CMD_W-1:0]    command;
	logic [peds_pkg::PERIOD_W-1:0] period;
	modport source (output valid, command, period, input ready);
	modport sink (input valid, command, period, output ready);
endinterface

interface peds_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [peds_pkg::STATUS_W-1:0] status;
	logic [peds_pkg::INDEX_W-1:0]  client_index;
	logic [peds_pkg::SEND_W-1:0]   send_time;
	modport source (output valid, status, client_index, send_time, input ready);
	modport sink (input valid, status, client_index, send_time, output ready);
endinterface

[hw/rtl/periodic_earliest_due_scheduler_unit.sv]
// Periodic earliest-due scheduler: binary min-heap of clients in one RAM.
// Clear resets the client count; add places the new entry last and sifts it up level by level;
// serve reads the top, stops on overflow, else advances its due by its period and sifts it down.
// One request at a time; next accept the cycle after the response is taken.
// Reset: client count and handshake state clear asynchronously; heap RAM is not reset.
// Depends on peds_pkg, peds_if, peds_heap_mem.
`timescale 1ns / 1ps
module periodic_earliest_due_scheduler_unit #(
	parameter int MAX_CLIENTS = 1024,
	parameter int PERIOD_BITS = 16,
	parameter int TIME_BITS   = 48
) (
	input  logic       clk,
	input  logic       arst_n,
	peds_req_if.sink   req,
	peds_rsp_if.source rsp
);
	import peds_pkg::*;

	localparam int AW  = (MAX_CLIENTS > 2) ? $clog2(MAX_CLIENTS) : 1;
	localparam int CW  = $clog2(MAX_CLIENTS + 1);
	localparam int IW  = CW;
	localparam int DW  = PERIOD_BITS + IW + TIME_BITS;

	typedef struct packed {
		logic [PERIOD_BITS-1:0] period;
		logic [IW-1:0]          index;
		logic [TIME_BITS-1:0]   due;
	} entry_t;

	state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic [AW-1:0] pos_q, other_q, best_q;
	entry_t cur_q, best_e_q, rd_e;
	logic [DW-1:0] rdata;
	logic [STATUS_W-1:0] status_q;
	logic [INDEX_W-1:0] idx_q;
	logic [SEND_W-1:0] time_q;
	logic rsp_valid_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	entry_t wdata;

	assign rd_e = entry_t'(rdata);

	peds_heap_mem #(.DEPTH(MAX_CLIENTS), .ADDR_W(AW), .DATA_W(DW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// shared comparator: a ahead of b
	function automatic logic ahead(input entry_t a, input entry_t b);
		if (a.due != b.due) begin
			return a.due < b.due;
		end
		return a.index < b.index;
	endfunction

	logic [AW-1:0] parent, lchild;
	logic [CW:0] l_ext, r_ext;
	logic [TIME_BITS:0] sum;
	logic rd_ahead;
	assign parent = AW'((pos_q - 1'b1) >> 1);
	assign l_ext  = (CW+1)'({pos_q, 1'b1});
	assign r_ext  = l_ext + 1'b1;
	assign lchild = l_ext[AW-1:0];
	// top entry advanced by its period; carry out means overflow
	assign sum    = {1'b0, rd_e.due} + (TIME_BITS+1)'(rd_e.period);
	assign rd_ahead = ahead(rd_e, best_e_q);

	assign req.ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.status = status_q;
	assign rsp.client_index = idx_q;
	assign rsp.send_time = time_q;

	wire accept = req.valid && req.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					priority case (cmd_t'(req.command))
						CMD_ADD:   state_d = (count_q >= CW'(MAX_CLIENTS)) ? S_DONE : S_UP_RD;
						CMD_SERVE: state_d = (count_q == '0) ? S_DONE : S_TOP_RD;
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_UP_RD:   state_d = (pos_q == '0) ? S_DONE : S_UP_CMP;
			S_UP_CMP:  state_d = ahead(cur_q, rd_e) ? S_UP_RD : S_DONE;
			S_TOP_RD:  state_d = S_TOP_CHK;
			S_TOP_CHK: state_d = sum[TIME_BITS] ? S_DONE : S_DN_RDL;
			S_DN_RDL:  state_d = (l_ext < (CW+1)'(count_q)) ? S_DN_RDR : S_DN_WR;
			S_DN_RDR:  state_d = S_DN_CMPL;
			S_DN_CMPL: state_d = S_DN_CMPR;
			S_DN_CMPR: state_d = S_DN_WR;
			S_DN_WR:   state_d = (best_q == pos_q) ? S_DONE : S_DN_RDL;
			S_DONE:    state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// RAM port control; read data shows up in the cycle after its address
	always_comb begin
		we = 1'b0;
		waddr = pos_q;
		wdata = cur_q;
		raddr = pos_q;
		unique case (state_q)
			S_UP_RD: begin
				raddr = parent;
				we = (pos_q == '0);
			end
			S_UP_CMP: begin
				we = 1'b1;
				if (ahead(cur_q, rd_e)) begin
					wdata = rd_e;
				end
			end
			S_TOP_RD:  raddr = '0;
			S_DN_RDL:  raddr = lchild;
			S_DN_RDR:  raddr = lchild;
			S_DN_CMPL: raddr = AW'(r_ext);
			S_DN_WR: begin
				we = 1'b1;
				if (best_q != pos_q) begin
					wdata = best_e_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (state_q == S_DONE) begin
				rsp_valid_q <= 1'b1;
			end
			if (accept && cmd_t'(req.command) == CMD_CLEAR) begin
				count_q <= '0;
			end
			if (accept && cmd_t'(req.command) == CMD_ADD && count_q < CW'(MAX_CLIENTS)) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					status_q <= ST_OK;
					idx_q <= '0;
					time_q <= '0;
					pos_q <= AW'(count_q);
					cur_q.period <= PERIOD_BITS'(req.period);
					cur_q.index <= IW'(count_q + 1'b1);
					cur_q.due <= TIME_BITS'(PERIOD_BITS'(req.period));
					if (cmd_t'(req.command) == CMD_ADD) begin
						if (count_q >= CW'(MAX_CLIENTS)) begin
							status_q <= ST_FULL;
						end else begin
							idx_q <= INDEX_W'(count_q + 1'b1);
						end
					end
					if (cmd_t'(req.command) == CMD_SERVE && count_q == '0) begin
						status_q <= ST_EMPTY;
					end
				end
			end
			S_UP_CMP: begin
				if (ahead(cur_q, rd_e)) begin
					pos_q <= parent;
				end
			end
			S_TOP_RD: pos_q <= '0;
			S_TOP_CHK: begin
				cur_q <= rd_e;
				idx_q <= INDEX_W'(rd_e.index);
				time_q <= SEND_W'(rd_e.due);
				if (sum[TIME_BITS]) begin
					status_q <= ST_OVF;
				end else begin
					cur_q.due <= sum[TIME_BITS-1:0];
				end
			end
			S_DN_RDL: begin
				best_q <= pos_q;
				best_e_q <= cur_q;
				other_q <= (r_ext < (CW+1)'(count_q)) ? AW'(r_ext) : pos_q;
			end
			S_DN_CMPL: begin
				if (rd_ahead) begin
					best_q <= lchild;
					best_e_q <= rd_e;
				end
			end
			S_DN_CMPR: begin
				if (other_q != pos_q && rd_ahead) begin
					best_q <= other_q;
					best_e_q <= rd_e;
				end
			end
			S_DN_WR: pos_q <= best_q;
			default: ;
		endcase
	end

`ifndef SYNTH
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !req.ready) else $error("ready while busy");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_CLIENTS)) else $error("client count overflow");
	a_done_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |=> rsp_valid_q) else $error("missing response");
`endif
endmodule

[hw/rtl/peds_heap_mem.sv]
// Heap entry storage: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
module peds_heap_mem #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10,
	parameter int DATA_W = 75
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);
	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
